/* sv/nbsm_pkg.sv */
// package: shared widths, codes, defaults and types for the bank switch mapper
package nbsm_pkg;

   // fixed field widths
   localparam int CmdW      = 2;
   localparam int AddrW     = 16;
   localparam int DataW     = 8;
   localparam int TargetW   = 2;
   localparam int RomAddrW  = 17;
   localparam int PrgMaskW  = 17;
   localparam int ChrMaskW  = 16;
   localparam int CsrDataW  = 17;
   localparam int CsrIndexW = 1;

   // parameter defaults
   localparam int PrgAddrBitsDefault = 17;
   localparam int ChrAddrBitsDefault = 16;

   // bank granularity
   localparam int PrgBankShift  = 13;
   localparam int ChrBankShift  = 11;
   localparam int PrgFixedShift = 14;

   // access kinds
   localparam logic [CmdW-1:0] CmdCpuWrite = 2'd0;
   localparam logic [CmdW-1:0] CmdCpuRead  = 2'd1;
   localparam logic [CmdW-1:0] CmdPpuRead  = 2'd2;

   // result targets
   localparam logic [TargetW-1:0] TargetNone = 2'd0;
   localparam logic [TargetW-1:0] TargetPrg  = 2'd1;
   localparam logic [TargetW-1:0] TargetChr  = 2'd2;

   // register write addresses on the cpu bus
   localparam logic [AddrW-1:0] SelectAddr   = 16'h8000;
   localparam logic [AddrW-1:0] BankDataAddr = 16'h8001;

   // cpu address regions, top three address bits
   localparam logic [2:0] RegionPrg0 = 3'b100;
   localparam logic [2:0] RegionPrg1 = 3'b101;
   // fixed window, top two address bits
   localparam logic [1:0] RegionFixed = 2'b11;

   // configuration register indexes
   localparam logic [CsrIndexW-1:0] CsrPrgSizeMask = 1'd0;
   localparam logic [CsrIndexW-1:0] CsrChrSizeMask = 1'd1;

   // bank selector codes of interest
   localparam logic [2:0] SelChrFirst = 3'd2;
   localparam logic [2:0] SelChrLast  = 3'd5;
   localparam logic [2:0] SelPrgFirst = 3'd6;

   // bank register write event from the pipeline
   typedef struct packed {
      logic             sel_we;
      logic             bank_we;
      logic [DataW-1:0] data;
   } bank_write_type;

endpackage

/* sv/nbsm_if.sv */
// interfaces: request and response channels of the bank switch mapper
interface nbsm_req_if;
   logic                          valid;
   logic                          ready;
   logic [nbsm_pkg::CmdW-1:0]     cmd;
   logic [nbsm_pkg::AddrW-1:0]    bus_addr;
   logic [nbsm_pkg::DataW-1:0]    write_data;

   modport source (output valid, output cmd, output bus_addr, output write_data,
                   input ready);
   modport sink   (input valid, input cmd, input bus_addr, input write_data,
                   output ready);
endinterface

interface nbsm_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [nbsm_pkg::TargetW-1:0]   target;
   logic [nbsm_pkg::RomAddrW-1:0]  rom_address;

   modport source (output valid, output target, output rom_address, input ready);
   modport sink   (input valid, input target, input rom_address, output ready);
endinterface

/* sv/nbsm_bank_regs.sv */
// bank register file: selector, chr and prg bank bases, rom size masks
module nbsm_bank_regs #(
   parameter int PRG_ADDR_BITS = nbsm_pkg::PrgAddrBitsDefault,
   parameter int CHR_ADDR_BITS = nbsm_pkg::ChrAddrBitsDefault,
   localparam int PrgW = (PRG_ADDR_BITS < nbsm_pkg::PrgMaskW) ?
                         PRG_ADDR_BITS : nbsm_pkg::PrgMaskW,
   localparam int ChrW = (CHR_ADDR_BITS < nbsm_pkg::ChrMaskW) ?
                         CHR_ADDR_BITS : nbsm_pkg::ChrMaskW
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [nbsm_pkg::CsrIndexW-1:0]      csr_index,
   input  logic [nbsm_pkg::CsrDataW-1:0]       csr_data,
   input  nbsm_pkg::bank_write_type            wr,
   output logic [PrgW-1:0]                     prg_mask,
   output logic [3:0][ChrW-1:0]                chr_bases,
   output logic [1:0][PrgW-1:0]                prg_bases
);

   localparam int PrgShW = nbsm_pkg::DataW + nbsm_pkg::PrgBankShift;
   localparam int ChrShW = nbsm_pkg::DataW + nbsm_pkg::ChrBankShift;

   logic [PrgW-1:0]        prg_mask_ff, prg_mask_in;
   logic [ChrW-1:0]        chr_mask_ff, chr_mask_in;
   logic [2:0]             sel_ff, sel_in;
   logic [3:0][ChrW-1:0]   chr_base_ff, chr_base_in;
   logic [1:0][PrgW-1:0]   prg_base_ff, prg_base_in;

   logic [PrgShW-1:0]      prg_shifted;
   logic [ChrShW-1:0]      chr_shifted;
   logic [PrgW-1:0]        prg_keep, prg_value;
   logic [ChrW-1:0]        chr_keep, chr_value;
   logic [2:0]             chr_slot;

   // shifted and masked bank values
   always_comb begin
      prg_shifted = {wr.data, {nbsm_pkg::PrgBankShift{1'b0}}};
      chr_shifted = {wr.data, {nbsm_pkg::ChrBankShift{1'b0}}};
      prg_keep    = {prg_mask_ff[PrgW-1:nbsm_pkg::PrgBankShift],
                     {nbsm_pkg::PrgBankShift{1'b0}}};
      chr_keep    = {chr_mask_ff[ChrW-1:nbsm_pkg::ChrBankShift],
                     {nbsm_pkg::ChrBankShift{1'b0}}};
      prg_value   = prg_shifted[PrgW-1:0] & prg_keep;
      chr_value   = chr_shifted[ChrW-1:0] & chr_keep;
      chr_slot    = sel_ff - nbsm_pkg::SelChrFirst;
   end

   // next state of selector and banks
   always_comb begin
      sel_in      = sel_ff;
      chr_base_in = chr_base_ff;
      prg_base_in = prg_base_ff;
      if (wr.sel_we) begin
         sel_in = wr.data[2:0];
      end
      if (wr.bank_we) begin
         if (sel_ff >= nbsm_pkg::SelChrFirst && sel_ff <= nbsm_pkg::SelChrLast) begin
            chr_base_in[chr_slot[1:0]] = chr_value;
         end else if (sel_ff >= nbsm_pkg::SelPrgFirst) begin
            prg_base_in[sel_ff[0]] = prg_value;
         end
      end
   end

   // size mask writes
   always_comb begin
      prg_mask_in = prg_mask_ff;
      chr_mask_in = chr_mask_ff;
      if (csr_we) begin
         case (csr_index)
            nbsm_pkg::CsrPrgSizeMask: prg_mask_in = csr_data[PrgW-1:0];
            nbsm_pkg::CsrChrSizeMask: chr_mask_in = csr_data[ChrW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_mask_ff <= '1;
         chr_mask_ff <= '1;
         sel_ff      <= '0;
         chr_base_ff <= '0;
         prg_base_ff <= '0;
      end else begin
         prg_mask_ff <= prg_mask_in;
         chr_mask_ff <= chr_mask_in;
         sel_ff      <= sel_in;
         chr_base_ff <= chr_base_in;
         prg_base_ff <= prg_base_in;
      end
   end

   assign prg_mask  = prg_mask_ff;
   assign chr_bases = chr_base_ff;
   assign prg_bases = prg_base_ff;

endmodule

/* sv/nbsm_translate.sv */
// address translation: bus access to target memory and rom offset
module nbsm_translate #(
   parameter int PRG_ADDR_BITS = nbsm_pkg::PrgAddrBitsDefault,
   parameter int CHR_ADDR_BITS = nbsm_pkg::ChrAddrBitsDefault,
   localparam int PrgW = (PRG_ADDR_BITS < nbsm_pkg::PrgMaskW) ?
                         PRG_ADDR_BITS : nbsm_pkg::PrgMaskW,
   localparam int ChrW = (CHR_ADDR_BITS < nbsm_pkg::ChrMaskW) ?
                         CHR_ADDR_BITS : nbsm_pkg::ChrMaskW
) (
   input  logic [nbsm_pkg::CmdW-1:0]       cmd,
   input  logic [nbsm_pkg::AddrW-1:0]      bus_addr,
   input  logic [PrgW-1:0]                 prg_mask,
   input  logic [3:0][ChrW-1:0]            chr_bases,
   input  logic [1:0][PrgW-1:0]            prg_bases,
   output logic [nbsm_pkg::TargetW-1:0]    target,
   output logic [nbsm_pkg::RomAddrW-1:0]   rom_address
);

   logic [2:0]      region;
   logic [PrgW-1:0] prg_win0, prg_win1, prg_fixed;
   logic [ChrW-1:0] chr_off;

   // candidate offsets for each window
   always_comb begin
      region    = bus_addr[15:13];
      prg_win0  = prg_bases[0] | PrgW'(bus_addr[nbsm_pkg::PrgBankShift-1:0]);
      prg_win1  = prg_bases[1] | PrgW'(bus_addr[nbsm_pkg::PrgBankShift-1:0]);
      prg_fixed = {prg_mask[PrgW-1:nbsm_pkg::PrgFixedShift],
                   bus_addr[nbsm_pkg::PrgFixedShift-1:0]};
      chr_off   = chr_bases[bus_addr[12:11]] |
                  ChrW'(bus_addr[nbsm_pkg::ChrBankShift-1:0]);
   end

   // pick target and offset by access kind and region
   always_comb begin
      target      = nbsm_pkg::TargetNone;
      rom_address = '0;
      case (cmd)
         nbsm_pkg::CmdCpuRead: begin
            if (region == nbsm_pkg::RegionPrg0) begin
               target      = nbsm_pkg::TargetPrg;
               rom_address = nbsm_pkg::RomAddrW'(prg_win0);
            end else if (region == nbsm_pkg::RegionPrg1) begin
               target      = nbsm_pkg::TargetPrg;
               rom_address = nbsm_pkg::RomAddrW'(prg_win1);
            end else if (region[2:1] == nbsm_pkg::RegionFixed) begin
               target      = nbsm_pkg::TargetPrg;
               rom_address = nbsm_pkg::RomAddrW'(prg_fixed);
            end
         end
         nbsm_pkg::CmdPpuRead: begin
            // pattern tables only, below 0x2000 of the 14-bit ppu space
            if (!bus_addr[13]) begin
               target      = nbsm_pkg::TargetChr;
               rom_address = nbsm_pkg::RomAddrW'(chr_off);
            end
         end
         default: ;
      endcase
   end

endmodule

/* sv/nes_bank_switch_mapper.sv */
// top level: two-stage bank switch mapper with config port and bank registers
//
//  channel  | dir | handshake     | payload
//  req_ch   | in  | valid/ready   | cmd, bus_addr, write_data
//  rsp_ch   | out | valid/ready   | target, rom_address
//  csr_*    | in  | csr_we only   | csr_index, csr_data
//
//  one item per cycle sustained while the output accepts; a result passes
//  through the input register, then the result register behind the translation logic
//  bank register writes take effect when the item leaves the input register
//  synchronous active-high reset clears the pipeline, selector and banks and
//  sets both size masks to all ones
//  a stalled result register holds its item; the input register keeps
//  accepting as long as the item ahead of it can move

module nes_bank_switch_mapper #(
   parameter int PRG_ADDR_BITS = nbsm_pkg::PrgAddrBitsDefault,
   parameter int CHR_ADDR_BITS = nbsm_pkg::ChrAddrBitsDefault
) (
   input  logic                            clock,
   input  logic                            reset,
   nbsm_req_if.sink                        req_ch,
   nbsm_rsp_if.source                      rsp_ch,
   input  logic                            csr_we,
   input  logic [nbsm_pkg::CsrIndexW-1:0]  csr_index,
   input  logic [nbsm_pkg::CsrDataW-1:0]   csr_data
);

   localparam int PrgW = (PRG_ADDR_BITS < nbsm_pkg::PrgMaskW) ?
                         PRG_ADDR_BITS : nbsm_pkg::PrgMaskW;
   localparam int ChrW = (CHR_ADDR_BITS < nbsm_pkg::ChrMaskW) ?
                         CHR_ADDR_BITS : nbsm_pkg::ChrMaskW;

   // input stage
   logic                              v1_ff, v1_in;
   logic [nbsm_pkg::CmdW-1:0]         cmd1_ff;
   logic [nbsm_pkg::AddrW-1:0]        addr1_ff;
   logic [nbsm_pkg::DataW-1:0]        data1_ff;

   // result stage
   logic                              v2_ff, v2_in;
   logic [nbsm_pkg::TargetW-1:0]      target2_ff, target2_in;
   logic [nbsm_pkg::RomAddrW-1:0]     rom2_ff, rom2_in;

   logic                              req_fire, s1_fire, s2_ready;
   nbsm_pkg::bank_write_type          wr;
   logic [PrgW-1:0]                   prg_mask;
   logic [3:0][ChrW-1:0]              chr_bases;
   logic [1:0][PrgW-1:0]              prg_bases;

   // handshake and stage advance
   always_comb begin
      s2_ready = !v2_ff || rsp_ch.ready;
      s1_fire  = v1_ff && s2_ready;
      req_fire = req_ch.valid && req_ch.ready;
      v1_in    = req_fire || (v1_ff && !s1_fire);
      v2_in    = s1_fire || (v2_ff && !rsp_ch.ready);
   end

   assign req_ch.ready = !v1_ff || s2_ready;

   // bank register writes from the item leaving the input stage
   always_comb begin
      wr.sel_we  = s1_fire && cmd1_ff == nbsm_pkg::CmdCpuWrite &&
                   addr1_ff == nbsm_pkg::SelectAddr;
      wr.bank_we = s1_fire && cmd1_ff == nbsm_pkg::CmdCpuWrite &&
                   addr1_ff == nbsm_pkg::BankDataAddr;
      wr.data    = data1_ff;
   end

   nbsm_bank_regs #(
      .PRG_ADDR_BITS (PRG_ADDR_BITS),
      .CHR_ADDR_BITS (CHR_ADDR_BITS)
   ) u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .wr        (wr),
      .prg_mask  (prg_mask),
      .chr_bases (chr_bases),
      .prg_bases (prg_bases)
   );

   nbsm_translate #(
      .PRG_ADDR_BITS (PRG_ADDR_BITS),
      .CHR_ADDR_BITS (CHR_ADDR_BITS)
   ) u_xlate (
      .cmd         (cmd1_ff),
      .bus_addr    (addr1_ff),
      .prg_mask    (prg_mask),
      .chr_bases   (chr_bases),
      .prg_bases   (prg_bases),
      .target      (target2_in),
      .rom_address (rom2_in)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd1_ff  <= req_ch.cmd;
         addr1_ff <= req_ch.bus_addr;
         data1_ff <= req_ch.write_data;
      end
      if (s1_fire) begin
         target2_ff <= target2_in;
         rom2_ff    <= rom2_in;
      end
   end

   assign rsp_ch.valid       = v2_ff;
   assign rsp_ch.target      = target2_ff;
   assign rsp_ch.rom_address = rom2_ff;

`ifndef SYNTHESIS
   // unmapped results carry a zero offset
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && target2_ff == nbsm_pkg::TargetNone) |-> rom2_ff == '0)
      else $error("unmapped result with nonzero rom address");

   // input side only stalls when both stages are full and the output is blocked
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (v1_ff && v2_ff && !rsp_ch.ready))
      else $error("input stalled with room in the pipeline");

   // a bank register write never produces a mapped result
   a_write_none: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && cmd1_ff == nbsm_pkg::CmdCpuWrite) |=>
      target2_ff == nbsm_pkg::TargetNone)
      else $error("cpu write produced a mapped result");

   // pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (!v1_ff && !v2_ff))
      else $error("pipeline not empty after reset");
`endif

endmodule
